[hdl/duration_text_parser_defines.svh]
// Assertion macros for the duration text parser.
`ifndef DURATION_TEXT_PARSER_DEFINES_SVH
`define DURATION_TEXT_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DTP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DTP_ASSERT(lbl, prop, msg)
`define DTP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[hdl/dtp_pkg.sv]
package dtp_pkg;

    typedef logic [4:0] t_sfx;

    localparam t_sfx SfxIdle  = 5'd0;
    localparam t_sfx SfxNow   = 5'd1;
    localparam t_sfx SfxDay   = 5'd3;
    localparam t_sfx SfxHour  = 5'd5;
    localparam t_sfx SfxMin   = 5'd8;
    localparam t_sfx SfxSec   = 5'd13;
    localparam t_sfx SfxLimit = 5'd18;

    localparam logic [31:0] ErrorValue = 32'hFFFF_FFFF;
    localparam logic [31:0] SecPerDay  = 32'd86400;
    localparam logic [31:0] SecPerHour = 32'd3600;
    localparam logic [31:0] SecPerMin  = 32'd60;
    localparam logic [31:0] SecPerSec  = 32'd1;
    localparam logic [31:0] MaxMinSec  = 32'd59;

    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] Ch0     = 8'h30;
    localparam logic [7:0] Ch9     = 8'h39;
    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChA     = 8'h41;
    localparam logic [7:0] ChC     = 8'h43;
    localparam logic [7:0] ChD     = 8'h44;
    localparam logic [7:0] ChE     = 8'h45;
    localparam logic [7:0] ChH     = 8'h48;
    localparam logic [7:0] ChI     = 8'h49;
    localparam logic [7:0] ChM     = 8'h4D;
    localparam logic [7:0] ChN     = 8'h4E;
    localparam logic [7:0] ChO     = 8'h4F;
    localparam logic [7:0] ChR     = 8'h52;
    localparam logic [7:0] ChS     = 8'h53;
    localparam logic [7:0] ChT     = 8'h54;
    localparam logic [7:0] ChU     = 8'h55;
    localparam logic [7:0] ChW     = 8'h57;
    localparam logic [7:0] ChY     = 8'h59;
    localparam logic [7:0] ChNone  = 8'h00;

    typedef struct packed {
        logic       en;
        logic       last;
        logic [7:0] code;
    } t_step;

    typedef struct packed {
        logic        err;
        logic [31:0] value;
    } t_verdict;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= Ch0) && (c <= Ch9);
    endfunction

    // unit word matcher: letter expected in each position
    function automatic logic [7:0] sfx_expect(input t_sfx st);
        case (st)
            5'd1:    return ChO;
            5'd2:    return ChW;
            5'd3:    return ChA;
            5'd4:    return ChY;
            5'd5:    return ChO;
            5'd6:    return ChU;
            5'd7:    return ChR;
            5'd8:    return ChI;
            5'd9:    return ChN;
            5'd10:   return ChU;
            5'd11:   return ChT;
            5'd12:   return ChE;
            5'd13:   return ChE;
            5'd14:   return ChC;
            5'd15:   return ChO;
            5'd16:   return ChN;
            5'd17:   return ChD;
            default: return ChNone;
        endcase
    endfunction

    function automatic t_sfx sfx_next(input t_sfx st);
        case (st)
            5'd1:    return 5'd2;
            5'd3:    return 5'd4;
            5'd5:    return 5'd6;
            5'd6:    return 5'd7;
            5'd8:    return 5'd9;
            5'd9:    return 5'd10;
            5'd10:   return 5'd11;
            5'd11:   return 5'd12;
            5'd13:   return 5'd14;
            5'd14:   return 5'd15;
            5'd15:   return 5'd16;
            5'd16:   return 5'd17;
            default: return SfxIdle;
        endcase
    endfunction

    // 1 where the rest of the word may be absent
    function automatic logic sfx_optional(input t_sfx st);
        case (st)
            5'd0, 5'd1, 5'd3, 5'd5, 5'd8, 5'd10, 5'd13, 5'd15: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

endpackage

[hdl/dtp_stream_if.sv]
interface dtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dtp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] duration_seconds;
    logic        parse_error;

    modport source (output valid, output duration_seconds, output parse_error, input ready);
    modport sink   (input valid, input duration_seconds, input parse_error, output ready);
endinterface

[hdl/duration_text_parser.sv]
// Channel   Dir  Beat payload                      Notes
// i_char    in   char_code[7:0], last_char         one character per beat
// o_result  out  duration_seconds[31:0], parse_error  one beat per string
//
// One character per cycle unless stalled: input register, then an update of
// both readers, with the result register loaded on the last character.
// The last character passes the input register, then the result register.
// A pending result stalls only a following last character; others proceed.
// Synchronous active-low reset clears all reader state and both valids.
`include "duration_text_parser_defines.svh"

module duration_text_parser (
    input logic       i_clk,
    input logic       i_rst_n,
    dtp_in_if.sink    i_char,
    dtp_out_if.source o_result
);

    logic        r_in_valid;
    logic [7:0]  r_in_code;
    logic        r_in_last;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic        r_out_err;

    logic              advance;
    logic              colon_active;
    dtp_pkg::t_step    step;
    dtp_pkg::t_verdict unit_v;
    dtp_pkg::t_verdict colon_v;
    dtp_pkg::t_verdict pick;

    assign advance      = !r_in_last || !r_out_valid || o_result.ready;
    assign i_char.ready = !r_in_valid || advance;

    assign step.en   = r_in_valid && advance;
    assign step.last = r_in_last;
    assign step.code = r_in_code;

    dtp_unit_reader u_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .o_verdict (unit_v)
    );

    dtp_colon_reader u_colon (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .o_active  (colon_active),
        .o_verdict (colon_v)
    );

    assign pick = colon_active ? colon_v : unit_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (step.en && step.last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_code <= i_char.char_code;
            r_in_last <= i_char.last_char;
        end
        if (step.en && step.last) begin
            r_out_value <= pick.value;
            r_out_err   <= pick.err;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.duration_seconds = r_out_value;
    assign o_result.parse_error      = r_out_err;

    `DTP_ASSERT(a_stall_blocks_input, (r_in_valid && r_in_last && r_out_valid && !o_result.ready) |-> !i_char.ready, "input taken while last character is stalled")
    `DTP_ASSERT(a_result_from_last, $rose(o_result.valid) |-> $past(r_in_valid && r_in_last), "result without a last character")
    `DTP_ASSERT_RST(a_reset_clears_out, $past(!i_rst_n) |-> !o_result.valid, "result valid right after reset")

endmodule

[hdl/dtp_unit_reader.sv]
module dtp_unit_reader (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtp_pkg::t_step    i_step,
    output dtp_pkg::t_verdict o_verdict
);

    logic [31:0]   r_total, n_total;
    logic [31:0]   r_accum, n_accum;
    dtp_pkg::t_sfx r_sfx, n_sfx;
    logic          r_err, n_err;

    dtp_pkg::t_sfx st;
    dtp_pkg::t_sfx unit_sfx;
    logic [7:0]    c;
    logic          fall;
    logic          unit_hit;
    logic [31:0]   mult;
    logic [31:0]   base;
    logic [31:0]   sum;

    assign c = i_step.code;

    always_comb begin
        unit_hit = 1'b1;
        mult     = dtp_pkg::SecPerSec;
        unit_sfx = dtp_pkg::SfxSec;
        case (c)
            dtp_pkg::ChD: begin
                mult     = dtp_pkg::SecPerDay;
                unit_sfx = dtp_pkg::SfxDay;
            end
            dtp_pkg::ChH: begin
                mult     = dtp_pkg::SecPerHour;
                unit_sfx = dtp_pkg::SfxHour;
            end
            dtp_pkg::ChM: begin
                mult     = dtp_pkg::SecPerMin;
                unit_sfx = dtp_pkg::SfxMin;
            end
            dtp_pkg::ChS: begin
                mult     = dtp_pkg::SecPerSec;
                unit_sfx = dtp_pkg::SfxSec;
            end
            default: unit_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_total = r_total;
        n_accum = r_accum;
        n_sfx   = r_sfx;
        n_err   = r_err;
        st      = (r_sfx >= dtp_pkg::SfxLimit) ? dtp_pkg::SfxIdle : r_sfx;
        base    = (r_accum == 32'd0) ? 32'd1 : r_accum;
        fall    = 1'b1;

        if (r_err) begin
            fall = 1'b0;
        end else if (st != dtp_pkg::SfxIdle) begin
            if (c == dtp_pkg::sfx_expect(st)) begin
                n_sfx = dtp_pkg::sfx_next(st);
                fall  = 1'b0;
            end else if (st == dtp_pkg::SfxHour && c == dtp_pkg::ChR) begin
                n_sfx = dtp_pkg::SfxIdle;
                fall  = 1'b0;
            end else if (!dtp_pkg::sfx_optional(st)) begin
                n_err = 1'b1;
                fall  = 1'b0;
            end else begin
                n_sfx = dtp_pkg::SfxIdle;
            end
        end

        if (fall) begin
            if (c == dtp_pkg::ChSpace || c == dtp_pkg::ChTab) begin
                n_accum = r_accum;
            end else if (dtp_pkg::is_digit(c)) begin
                n_accum = (r_accum << 3) + (r_accum << 1) + {28'd0, c[3:0]};
            end else if (c == dtp_pkg::ChN) begin
                n_total = 32'd0;
                n_accum = 32'd0;
                n_sfx   = dtp_pkg::SfxNow;
            end else if (unit_hit) begin
                n_total = r_total + 32'(base * mult);
                n_accum = 32'd0;
                n_sfx   = unit_sfx;
            end else begin
                n_err = 1'b1;
            end
        end
    end

    assign sum             = n_total + n_accum;
    assign o_verdict.err   = n_err || !dtp_pkg::sfx_optional(n_sfx);
    assign o_verdict.value = o_verdict.err ? dtp_pkg::ErrorValue : sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= 32'd0;
            r_accum <= 32'd0;
            r_sfx   <= dtp_pkg::SfxIdle;
            r_err   <= 1'b0;
        end else if (i_step.en) begin
            if (i_step.last) begin
                r_total <= 32'd0;
                r_accum <= 32'd0;
                r_sfx   <= dtp_pkg::SfxIdle;
                r_err   <= 1'b0;
            end else begin
                r_total <= n_total;
                r_accum <= n_accum;
                r_sfx   <= n_sfx;
                r_err   <= n_err;
            end
        end
    end

endmodule

[hdl/dtp_colon_reader.sv]
module dtp_colon_reader (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtp_pkg::t_step    i_step,
    output logic              o_active,
    output dtp_pkg::t_verdict o_verdict
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_POS,
        PH_NEG,
        PH_DONE
    } t_phase;

    logic [1:0]  r_count, n_count;
    logic [31:0] r_val [3];
    logic [31:0] n_val [3];
    t_phase      r_phase, n_phase;

    logic [7:0]  c;
    logic [1:0]  f;
    logic [31:0] cur;
    logic [31:0] cur_x10;
    logic [31:0] digit;
    t_phase      ph;
    logic        skip;
    logic        is_ws;
    logic        three;
    logic        err;
    logic [31:0] hms;
    logic [31:0] ms;

    assign c       = i_step.code;
    assign f       = r_count[1] ? 2'd2 : r_count;
    assign cur     = r_val[f];
    assign cur_x10 = (cur << 3) + (cur << 1);
    assign digit   = {28'd0, c[3:0]};
    assign is_ws   = (c == dtp_pkg::ChSpace) || (c >= dtp_pkg::ChTab && c <= dtp_pkg::ChCr);

    always_comb begin
        n_count = r_count;
        n_val   = r_val;
        n_phase = r_phase;
        ph      = r_phase;
        skip    = 1'b0;
        if (c == dtp_pkg::ChColon) begin
            if (f != 2'd2) begin
                n_count = f + 2'd1;
                n_phase = PH_SKIP;
            end else begin
                n_phase = PH_DONE;
            end
        end else begin
            if (ph == PH_SKIP) begin
                if (is_ws) begin
                    skip = 1'b1;
                end else if (c == dtp_pkg::ChPlus) begin
                    n_phase = PH_POS;
                    skip    = 1'b1;
                end else if (c == dtp_pkg::ChMinus) begin
                    n_phase = PH_NEG;
                    skip    = 1'b1;
                end else begin
                    ph      = PH_POS;
                    n_phase = PH_POS;
                end
            end
            if (!skip && (ph == PH_POS || ph == PH_NEG)) begin
                if (dtp_pkg::is_digit(c)) begin
                    n_val[f] = (ph == PH_POS) ? cur_x10 + digit : cur_x10 - digit;
                end else begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    assign three = n_count[1];
    assign hms   = 32'(n_val[0] * dtp_pkg::SecPerHour) + 32'(n_val[1] * dtp_pkg::SecPerMin)
                 + n_val[2];
    assign ms    = 32'(n_val[0] * dtp_pkg::SecPerMin) + n_val[1];
    assign err   = (n_val[1] > dtp_pkg::MaxMinSec) || (three && (n_val[2] > dtp_pkg::MaxMinSec));

    assign o_active        = (n_count != 2'd0);
    assign o_verdict.err   = err;
    assign o_verdict.value = err ? dtp_pkg::ErrorValue : (three ? hms : ms);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_val   <= '{default: 32'd0};
            r_phase <= PH_SKIP;
        end else if (i_step.en) begin
            if (i_step.last) begin
                r_count <= 2'd0;
                r_val   <= '{default: 32'd0};
                r_phase <= PH_SKIP;
            end else begin
                r_count <= n_count;
                r_val   <= n_val;
                r_phase <= n_phase;
            end
        end
    end

endmodule

[sim/duration_text_parser_tb.sv]
module duration_text_parser_tb;

    typedef struct packed {
        logic       last;
        logic [7:0] code;
    } t_char_beat;

    typedef struct packed {
        logic        err;
        logic [31:0] value;
    } t_reading;

    typedef enum logic [1:0] {FieldBlank, FieldPos, FieldNeg, FieldDone} t_field_phase;

    localparam int unsigned IdlePct = 32;

    logic i_clk;
    logic i_rst_n;

    dtp_in_if  chan_in ();
    dtp_out_if chan_out ();

    duration_text_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (chan_in),
        .o_result (chan_out)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // unit word matcher: letter expected, following position, rest may be absent
    logic [7:0] word_letter [18] = '{dtp_pkg::ChNone, dtp_pkg::ChO, dtp_pkg::ChW,
                                     dtp_pkg::ChA, dtp_pkg::ChY, dtp_pkg::ChO,
                                     dtp_pkg::ChU, dtp_pkg::ChR, dtp_pkg::ChI,
                                     dtp_pkg::ChN, dtp_pkg::ChU, dtp_pkg::ChT,
                                     dtp_pkg::ChE, dtp_pkg::ChE, dtp_pkg::ChC,
                                     dtp_pkg::ChO, dtp_pkg::ChN, dtp_pkg::ChD};
    dtp_pkg::t_sfx word_next [18] = '{5'd0, 5'd2, 5'd0, 5'd4, 5'd0, 5'd6, 5'd7, 5'd0, 5'd9,
                                      5'd10, 5'd11, 5'd12, 5'd0, 5'd14, 5'd15, 5'd16,
                                      5'd17, 5'd0};
    bit         word_opt    [18] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                                     1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

    logic [31:0]   unit_sum;
    logic [31:0]   number;
    dtp_pkg::t_sfx word_pos;
    logic          unit_bad;
    logic [1:0]    colons;
    logic [31:0]   fields [3];
    t_field_phase  field_phase;

    t_char_beat  char_pending [$];
    t_reading    durations_due [$];
    logic [7:0]  text [$];
    int unsigned chars_queued;
    int unsigned bad_results;
    logic        char_taken;
    bit          quiet;
    bit          hold_go;

    function automatic void clear_parse();
        unit_sum    = '0;
        number      = '0;
        word_pos    = dtp_pkg::SfxIdle;
        unit_bad    = 1'b0;
        colons      = '0;
        fields[0]   = '0;
        fields[1]   = '0;
        fields[2]   = '0;
        field_phase = FieldBlank;
    endfunction

    function automatic void add_term(logic [31:0] mult, dtp_pkg::t_sfx next_pos);
        if (number == 0) begin
            number = 32'd1;
        end
        unit_sum = unit_sum + number * mult;
        number   = '0;
        word_pos = next_pos;
    endfunction

    // advances both readings by one character; returns 1 with a reading on the last one
    function automatic bit parse_char(input logic [7:0] c, input logic fin,
                                      output t_reading r);
        dtp_pkg::t_sfx st;
        int unsigned   f;
        bit            take;
        logic [31:0]   value;
        logic          err;
        if (!unit_bad) begin
            st = (word_pos >= dtp_pkg::SfxLimit) ? dtp_pkg::SfxIdle : word_pos;
            if (st != dtp_pkg::SfxIdle && c == word_letter[st]) begin
                word_pos = word_next[st];
            end else if (st == dtp_pkg::SfxHour && c == dtp_pkg::ChR) begin
                word_pos = dtp_pkg::SfxIdle;
            end else if (st != dtp_pkg::SfxIdle && !word_opt[st]) begin
                unit_bad = 1'b1;
            end else begin
                word_pos = dtp_pkg::SfxIdle;
                if (c >= dtp_pkg::Ch0 && c <= dtp_pkg::Ch9) begin
                    number = number * 32'd10 + 32'(c - dtp_pkg::Ch0);
                end else if (c != dtp_pkg::ChSpace && c != dtp_pkg::ChTab) begin
                    case (c)
                        dtp_pkg::ChN: begin
                            unit_sum = '0;
                            number   = '0;
                            word_pos = dtp_pkg::SfxNow;
                        end
                        dtp_pkg::ChD: add_term(dtp_pkg::SecPerDay, dtp_pkg::SfxDay);
                        dtp_pkg::ChH: add_term(dtp_pkg::SecPerHour, dtp_pkg::SfxHour);
                        dtp_pkg::ChM: add_term(dtp_pkg::SecPerMin, dtp_pkg::SfxMin);
                        dtp_pkg::ChS: add_term(dtp_pkg::SecPerSec, dtp_pkg::SfxSec);
                        default: unit_bad = 1'b1;
                    endcase
                end
            end
        end

        f = (colons > 2) ? 2 : colons;
        if (c == dtp_pkg::ChColon) begin
            if (f < 2) begin
                colons      = 2'(f + 1);
                field_phase = FieldBlank;
            end else begin
                field_phase = FieldDone;
            end
        end else begin
            take = 1'b1;
            if (field_phase == FieldBlank) begin
                if (c == dtp_pkg::ChSpace || (c >= dtp_pkg::ChTab && c <= dtp_pkg::ChCr)) begin
                    take = 1'b0;
                end else if (c == dtp_pkg::ChPlus) begin
                    field_phase = FieldPos;
                    take        = 1'b0;
                end else if (c == dtp_pkg::ChMinus) begin
                    field_phase = FieldNeg;
                    take        = 1'b0;
                end else begin
                    field_phase = FieldPos;
                end
            end
            if (take && field_phase != FieldDone) begin
                if (c >= dtp_pkg::Ch0 && c <= dtp_pkg::Ch9) begin
                    if (field_phase == FieldPos) begin
                        fields[f] = fields[f] * 32'd10 + 32'(c - dtp_pkg::Ch0);
                    end else begin
                        fields[f] = fields[f] * 32'd10 - 32'(c - dtp_pkg::Ch0);
                    end
                end else begin
                    field_phase = FieldDone;
                end
            end
        end

        if (!fin) begin
            return 1'b0;
        end
        if (colons != 0) begin
            err = fields[1] > dtp_pkg::MaxMinSec;
            if (colons >= 2) begin
                err   = err || (fields[2] > dtp_pkg::MaxMinSec);
                value = fields[0] * dtp_pkg::SecPerHour + fields[1] * dtp_pkg::SecPerMin
                      + fields[2];
            end else begin
                value = fields[0] * dtp_pkg::SecPerMin + fields[1];
            end
        end else begin
            err   = unit_bad || (word_pos >= dtp_pkg::SfxLimit) || !word_opt[word_pos];
            value = unit_sum + number;
        end
        r.err   = err;
        r.value = err ? dtp_pkg::ErrorValue : value;
        clear_parse();
        return 1'b1;
    endfunction

    function automatic void note_bad(string what, t_reading want, t_reading got);
        bad_results++;
        if (bad_results <= 10) begin
            $display("mismatch (%s): expected value %0d err %0b, got value %0d err %0b",
                     what, want.value, want.err, got.value, got.err);
        end
    endfunction

    // sender
    always @(negedge i_clk) begin
        t_char_beat beat;
        if (i_rst_n && (!chan_in.valid || char_taken)) begin
            if (char_pending.size() != 0 && (quiet || $urandom_range(0, 99) >= IdlePct)) begin
                beat = char_pending.pop_front();
                chan_in.valid     <= 1'b1;
                chan_in.char_code <= beat.code;
                chan_in.last_char <= beat.last;
            end else begin
                chan_in.valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge i_clk) begin
        int unsigned hold_left;
        bit          hold_done;
        if (hold_go && !hold_done) begin
            hold_left = 300;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            chan_out.ready <= 1'b0;
        end else begin
            chan_out.ready <= quiet || ($urandom_range(0, 99) >= IdlePct);
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        t_reading got;
        if (i_rst_n) begin
            char_taken <= chan_in.valid && chan_in.ready;
            if (chan_in.valid && chan_in.ready) begin
                if (parse_char(chan_in.char_code, chan_in.last_char, want)) begin
                    durations_due.push_back(want);
                end
            end
            if (chan_out.valid && chan_out.ready) begin
                got.value = chan_out.duration_seconds;
                got.err   = chan_out.parse_error;
                if (durations_due.size() == 0) begin
                    note_bad("nothing expected", '0, got);
                end else begin
                    want = durations_due.pop_front();
                    if (got.value !== want.value || got.err !== want.err) begin
                        note_bad("duration", want, got);
                    end
                end
            end
        end
    end

    task automatic put(logic [7:0] c);
        text.push_back(c);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            text.push_back(s[i]);
        end
    endtask

    task automatic put_noise_char();
        string pool;
        pool = "0123456789 :+-DHMSNOWAYURINTEC\t";
        if ($urandom_range(0, 1) == 0) begin
            put(8'($urandom_range(0, 255)));
        end else begin
            put(pool[$urandom_range(0, pool.len() - 1)]);
        end
    endtask

    task automatic put_blanks();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) put($urandom_range(0, 1) ? dtp_pkg::ChSpace
                                                                   : dtp_pkg::ChTab);
        end
    endtask

    task automatic put_number();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        n = (pick < 20) ? 0 : (pick < 80) ? $urandom_range(1, 2) :
            (pick < 95) ? $urandom_range(3, 5) : $urandom_range(9, 12);
        repeat (n) put(8'(dtp_pkg::Ch0 + $urandom_range(0, 9)));
    endtask

    task automatic put_unit();
        int unsigned form;
        form = $urandom_range(0, 2);
        case ($urandom_range(0, 3))
            0: begin
                if (form == 0) put_str("D");
                else put_str("DAY");
            end
            1: begin
                if (form == 0) put_str("H");
                else if (form == 1) put_str("HR");
                else put_str("HOUR");
            end
            2: begin
                if (form == 0) put_str("M");
                else if (form == 1) put_str("MIN");
                else put_str("MINUTE");
            end
            default: begin
                if (form == 0) put_str("S");
                else if (form == 1) put_str("SEC");
                else put_str("SECOND");
            end
        endcase
    endtask

    task automatic make_unit_text();
        if ($urandom_range(0, 5) == 0) begin
            put_str("NOW");
            put_blanks();
        end
        repeat ($urandom_range(1, 3)) begin
            put_number();
            put_blanks();
            put_unit();
            put_blanks();
            if ($urandom_range(0, 9) == 0) put_str("NOW");
        end
        if ($urandom_range(0, 3) == 0) put_number();
    endtask

    task automatic put_field();
        int unsigned pick;
        if ($urandom_range(0, 4) == 0) begin
            put($urandom_range(0, 1) ? dtp_pkg::ChSpace
                                     : 8'($urandom_range(dtp_pkg::ChTab, dtp_pkg::ChCr)));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) put(dtp_pkg::ChMinus);
        if (pick == 1) put(dtp_pkg::ChPlus);
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            put_str($sformatf("%0d", $urandom_range(0, 59)));
        end else if (pick < 85) begin
            put_str($sformatf("%0d", $urandom_range(60, 99)));
        end else if (pick < 95) begin
            put_str($sformatf("%0d", $urandom()));
        end
    endtask

    task automatic make_colon_text();
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(2, 3);
        for (int i = 0; i < n; i++) begin
            if (i > 0) put(dtp_pkg::ChColon);
            put_field();
        end
        if ($urandom_range(0, 4) == 0) put_noise_char();
    endtask

    task automatic make_random_text();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            make_unit_text();
        end else if (pick < 80) begin
            make_colon_text();
        end else if (pick < 92) begin
            if (pick < 86) make_unit_text();
            else make_colon_text();
            if (text.size() > 1 && $urandom_range(0, 1) == 0) begin
                void'(text.pop_back());
            end else begin
                text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end else begin
            repeat ($urandom_range(1, 8)) put_noise_char();
        end
    endtask

    task automatic send_text();
        t_char_beat beat;
        for (int i = 0; i < text.size(); i++) begin
            beat.code = text[i];
            beat.last = (i == text.size() - 1);
            char_pending.push_back(beat);
        end
        chars_queued += text.size();
        text.delete();
    endtask

    task automatic send_str(string s);
        put_str(s);
        send_text();
    endtask

    task automatic wait_drained();
        while (char_pending.size() != 0 || chan_in.valid || durations_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        chan_in.valid     = 1'b0;
        chan_in.char_code = '0;
        chan_in.last_char = 1'b0;
        chan_out.ready    = 1'b0;
        char_taken        = 1'b0;
        quiet             = 1'b0;
        hold_go           = 1'b0;
        chars_queued      = 0;
        bad_results       = 0;
        clear_parse();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extreme codes, bare unit, broken word, leftover number, extra colon, negative field, NOW
        put(8'hFF);
        send_text();
        put(dtp_pkg::ChNone);
        send_text();
        send_str("H");
        send_str("1DA");
        send_str("4SEC 7");
        send_str("1:2:3:4");
        send_str("-1:59");
        send_str("NOW");
        wait_drained();

        quiet = 1'b1;
        while (chars_queued < 200) begin
            make_random_text();
            send_text();
        end
        wait_drained();
        quiet = 1'b0;

        // receiver holds off while short strings keep coming
        hold_go = 1'b1;
        repeat (30) begin
            make_random_text();
            send_text();
        end
        wait_drained();

        while (chars_queued < 500) begin
            make_random_text();
            send_text();
        end
        wait_drained();
        while (chars_queued < 750) begin
            make_random_text();
            send_text();
        end
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (bad_results == 0) begin
            $display("** duration_text_parser: PASSED **");
        end else begin
            $display("** duration_text_parser: FAILED **");
        end
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("** duration_text_parser: FAILED **");
        $finish;
    end

endmodule
